FILE: design/olis_pkg.sv
// Package with the shared constants, codes and types of the ordered list block.
`default_nettype none

package olis_pkg;

    // Field widths of the command and result words.
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    // Default list depth.
    localparam int DEFAULT_MAX_ENTRIES = 16;

    // Number of match flags examined per cycle during a search scan.
    localparam int SCAN_LANES = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AT     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic              insert;
        logic              search;
        logic [VAL_W-1:0]  value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: design/olis_if.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none

interface olis_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [olis_pkg::CMD_W-1:0]         command;
    logic signed [olis_pkg::VAL_W-1:0]  value;
    logic [olis_pkg::POS_W-1:0]         position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink   (input valid, input command, input value, input position,
                    output ready);
endinterface

interface olis_res_if;
    logic                               valid;
    logic                               ready;
    logic [olis_pkg::POS_W-1:0]         found_position;
    logic [olis_pkg::STAT_W-1:0]        status;
    logic [olis_pkg::POS_W-1:0]         entry_count;

    modport source (output valid, output found_position, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input found_position, input status,
                    input entry_count, output ready);
endinterface

`default_nettype wire

FILE: design/ordered_list_insert_search_core.sv
// Top level of the ordered list block: command sequencer, result register and cell chain.
//
// Usage: command words arrive on i_cmd (valid/ready) and one result word per command
// leaves on o_res (valid/ready). The list holds up to MAX_ENTRIES signed 32-bit
// entries in a chain of cells, one entry per cell.
// An insert word shifts the cells behind the insert slot by one place;
// its result is registered at the accepting edge and is visible in the cycle after acceptance.
// A search word latches a match flag in every cell, then the sequencer scans the
// flags SCAN_LANES at a time, one group per cycle, and stops at the first hit.
// A search ends at the first group with a hit, or with a miss after the last group.
// Inserts sustain one word per cycle while the receiver keeps taking the results.
// Only one command is in work at a time; a new word is taken while the previous
// result waits in the output register, provided that register is freed that cycle.
// When the receiver stalls, the result stays in the output register and the block
// stops taking command words until it is taken.
// Reset empties the list and clears the output valid; entry contents are not cleared.
`default_nettype none

module ordered_list_insert_search_core #(
    parameter int MAX_ENTRIES = olis_pkg::DEFAULT_MAX_ENTRIES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    olis_cmd_if.sink   i_cmd,
    olis_res_if.source o_res
);

    localparam int IW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int PW     = (CW > olis_pkg::POS_W) ? CW : olis_pkg::POS_W;
    localparam int LANES  = olis_pkg::SCAN_LANES;
    localparam int LB     = $clog2(LANES);
    localparam int NCHUNK = (MAX_ENTRIES + LANES - 1) / LANES;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int HW     = CHW + LB + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Sequencer and result registers.
    logic                          r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CHW-1:0]                r_chunk, n_chunk;
    logic                          r_ovalid, n_ovalid;
    logic [olis_pkg::POS_W-1:0]    r_fpos, n_fpos;
    logic [olis_pkg::STAT_W-1:0]   r_stat, n_stat;
    logic [olis_pkg::POS_W-1:0]    r_ecnt, n_ecnt;

    // Chain signals.
    olis_pkg::t_cell_ctrl          w_ctrl;
    logic [IW-1:0]                 w_ins_idx;
    logic [olis_pkg::VAL_W-1:0]    w_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]        w_match;
    logic [NCHUNK*LANES-1:0]       w_match_pad;
    logic [LANES-1:0]              w_lane;

    logic                          w_ready;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_full;
    logic [PW-1:0]                 w_cnt_p;
    logic [PW-1:0]                 w_pos_p;
    logic [PW-1:0]                 w_idx_p;
    logic                          w_hit;
    logic [LB-1:0]                 w_hit_bit;
    logic [HW-1:0]                 w_hit_pos;
    logic                          w_last;

    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_ready    = i_rst_n && (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_cmd.valid && w_ready;
    assign w_full     = (r_count == CW'(MAX_ENTRIES));
    assign w_cnt_p    = PW'(r_count);
    assign w_pos_p    = PW'(i_cmd.position);

    // Insert slot: front, end, or the clamped 1-based position.
    always_comb begin
        case (i_cmd.command)
            olis_pkg::CMD_FRONT: w_idx_p = '0;
            olis_pkg::CMD_END:   w_idx_p = w_cnt_p;
            default: begin
                if (w_pos_p <= PW'(1)) begin
                    w_idx_p = '0;
                end else if (w_pos_p > w_cnt_p) begin
                    w_idx_p = w_cnt_p;
                end else begin
                    w_idx_p = w_pos_p - PW'(1);
                end
            end
        endcase
    end

    assign w_ins_idx = w_idx_p[IW-1:0];

    // Broadcast control to the chain.
    always_comb begin
        w_ctrl.value  = i_cmd.value;
        w_ctrl.search = w_accept && (i_cmd.command == olis_pkg::CMD_SEARCH);
        w_ctrl.insert = w_accept && (i_cmd.command != olis_pkg::CMD_SEARCH) && !w_full;
    end

    // Chain of cells; cell zero sees the new value as its neighbor.
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [olis_pkg::VAL_W-1:0] w_prev;
            if (g == 0) begin : g_head
                assign w_prev = i_cmd.value;
            end else begin : g_body
                assign w_prev = w_value[g-1];
            end
            olis_cell #(
                .MAX_ENTRIES (MAX_ENTRIES),
                .INDEX       (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_ins_idx    (w_ins_idx),
                .i_count      (r_count),
                .i_prev_value (w_prev),
                .o_value      (w_value[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // First match within the current group of match flags.
    assign w_match_pad = (NCHUNK*LANES)'(w_match);
    assign w_lane      = w_match_pad[r_chunk*LANES +: LANES];

    always_comb begin
        w_hit     = 1'b0;
        w_hit_bit = '0;
        for (int b = LANES - 1; b >= 0; b--) begin
            if (w_lane[b]) begin
                w_hit     = 1'b1;
                w_hit_bit = LB'(b);
            end
        end
    end

    assign w_hit_pos = {1'b0, r_chunk, w_hit_bit} + HW'(1);
    assign w_last    = (r_chunk == CHW'(NCHUNK - 1));

    // Sequencer next state.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_chunk  = r_chunk;
        n_ovalid = r_ovalid;
        n_fpos   = r_fpos;
        n_stat   = r_stat;
        n_ecnt   = r_ecnt;

        if (o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.command == olis_pkg::CMD_SEARCH) begin
                        n_state = S_SCAN;
                        n_chunk = '0;
                    end else if (w_full) begin
                        n_ovalid = 1'b1;
                        n_fpos   = '0;
                        n_stat   = olis_pkg::ST_FULL;
                        n_ecnt   = olis_pkg::POS_W'(r_count);
                    end else begin
                        n_count  = r_count + CW'(1);
                        n_ovalid = 1'b1;
                        n_fpos   = olis_pkg::POS_W'(w_idx_p + PW'(1));
                        n_stat   = olis_pkg::ST_OK;
                        n_ecnt   = olis_pkg::POS_W'(r_count + CW'(1));
                    end
                end
            end
            S_SCAN: begin
                if (w_hit || w_last) begin
                    if (w_out_free) begin
                        n_state  = S_IDLE;
                        n_ovalid = 1'b1;
                        n_fpos   = w_hit ? olis_pkg::POS_W'(w_hit_pos) : '0;
                        n_stat   = w_hit ? olis_pkg::ST_OK : olis_pkg::ST_MISS;
                        n_ecnt   = olis_pkg::POS_W'(r_count);
                    end
                end else begin
                    n_chunk = r_chunk + CHW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_chunk  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_chunk  <= n_chunk;
            r_ovalid <= n_ovalid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_fpos <= n_fpos;
        r_stat <= n_stat;
        r_ecnt <= n_ecnt;
    end

    assign i_cmd.ready          = w_ready;
    assign o_res.valid          = r_ovalid;
    assign o_res.found_position = r_fpos;
    assign o_res.status         = r_stat;
    assign o_res.entry_count    = r_ecnt;

endmodule

`default_nettype wire

FILE: design/olis_cell.sv
// One cell of the list chain: holds one entry, shifts on insert, compares on search.
`default_nettype none

module olis_cell #(
    parameter int MAX_ENTRIES = olis_pkg::DEFAULT_MAX_ENTRIES,
    parameter int INDEX       = 0
) (
    input  wire                                   i_clk,
    input  wire olis_pkg::t_cell_ctrl             i_ctrl,
    input  wire [$clog2(MAX_ENTRIES)-1:0]         i_ins_idx,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]       i_count,
    input  wire [olis_pkg::VAL_W-1:0]             i_prev_value,
    output logic [olis_pkg::VAL_W-1:0]            o_value,
    output logic                                  o_match
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    logic [olis_pkg::VAL_W-1:0] r_value;
    logic                       r_match;

    // Entries at and behind the insert slot take the neighbor's entry or the new value.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (MY_IDX > i_ins_idx) begin
                r_value <= i_prev_value;
            end else if (MY_IDX == i_ins_idx) begin
                r_value <= i_ctrl.value;
            end
        end
    end

    // A search latches whether this occupied entry equals the key.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.search) begin
            r_match <= (MY_CNT < i_count) && (r_value == i_ctrl.value);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

`default_nettype wire
